### sv/assert_macros.svh
// Assertion macros shared by the pair scorer RTL.
// No dependencies; included inside module bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked assertion, masked while reset is high.
`define RAP_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Assertion that also holds during reset.
`define RAP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### sv/rap_pkg.sv
// Shared types, widths and constants of the pair scorer.
// No dependencies.
package rap_pkg;

   localparam int COORD_W      = 24;
   localparam int DIFF_W       = COORD_W + 1;
   localparam int SQ_SUM_W     = 2 * COORD_W + 4;
   localparam int SCALE_W      = 48;
   localparam int OUT_W        = 32;
   localparam int CSR_IDX_W    = 2;
   localparam int MUL_A_W      = (SQ_SUM_W > 32) ? SQ_SUM_W : 32;
   localparam int MUL_B_W      = 48;
   localparam int MUL_DIGIT_W  = 16;
   localparam int MUL_NDIG     = MUL_B_W / MUL_DIGIT_W;
   localparam int MUL_P_W      = MUL_A_W + MUL_B_W;
   localparam int RECIP_W      = 36;
   localparam int RECIP_SHIFT  = 35;
   localparam int SERIES_TERMS = 14;

   localparam logic [32:0] LOG2E_Q32 = 33'd6196328019;
   localparam logic [31:0] LN2_Q32   = 32'd2977044472;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DIST_SCALE = 2'd0,
      CSR_CONF_SCALE = 2'd1
   } csr_index_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] first_x;
      logic signed [COORD_W-1:0] first_y;
      logic signed [COORD_W-1:0] first_z;
      logic signed [COORD_W-1:0] second_x;
      logic signed [COORD_W-1:0] second_y;
      logic signed [COORD_W-1:0] second_z;
      logic                      run_start;
      logic                      run_end;
   } req_type;

   typedef struct packed {
      logic        [OUT_W-1:0] probability;
      logic signed [OUT_W-1:0] dist_term;
      logic signed [OUT_W-1:0] conf_term;
      logic                    last_of_run;
   } rsp_type;

   // floor(2^35 / k) for the series divisors
   function automatic logic [RECIP_W-1:0] recip_q35(input logic [3:0] k);
      logic [RECIP_W-1:0] m;
      case (k)
         4'd1:    m = 36'd34359738368;
         4'd2:    m = 36'd17179869184;
         4'd3:    m = 36'd11453246122;
         4'd4:    m = 36'd8589934592;
         4'd5:    m = 36'd6871947673;
         4'd6:    m = 36'd5726623061;
         4'd7:    m = 36'd4908534052;
         4'd8:    m = 36'd4294967296;
         4'd9:    m = 36'd3817748707;
         4'd10:   m = 36'd3435973836;
         4'd11:   m = 36'd3123612578;
         4'd12:   m = 36'd2863311530;
         4'd13:   m = 36'd2643056797;
         4'd14:   m = 36'd2454267026;
         default: m = '0;
      endcase
      return m;
   endfunction

endpackage

### sv/rap_mul.sv
// Shared multiplier: wide A times 48-bit B, one 16-bit digit of B per cycle.
// Depends on rap_pkg.
module rap_mul (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [rap_pkg::MUL_A_W-1:0]  a,
   input  logic [rap_pkg::MUL_B_W-1:0]  b,
   output logic                         done,
   output logic [rap_pkg::MUL_P_W-1:0]  p
);
   import rap_pkg::*;

   localparam int CNT_W = $clog2(MUL_NDIG + 1);

   logic [MUL_A_W-1:0]             a_ff, a_in;
   logic [MUL_B_W-1:0]             b_ff, b_in;
   logic [MUL_P_W-1:0]             acc_ff, acc_in;
   logic [CNT_W-1:0]               cnt_ff, cnt_in;
   logic                           done_ff, done_in;
   logic [MUL_A_W+MUL_DIGIT_W-1:0] part;

   // partial product of the top remaining digit
   assign part = a_ff * b_ff[MUL_B_W-1 -: MUL_DIGIT_W];

   always_comb begin
      a_in    = a_ff;
      b_in    = b_ff;
      acc_in  = acc_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (start) begin
         a_in   = a;
         b_in   = b;
         acc_in = '0;
         cnt_in = CNT_W'(MUL_NDIG);
      end else if (cnt_ff != '0) begin
         acc_in  = {acc_ff[MUL_P_W-MUL_DIGIT_W-1:0], {MUL_DIGIT_W{1'b0}}}
                   + MUL_P_W'(part);
         b_in    = {b_ff[MUL_B_W-MUL_DIGIT_W-1:0], {MUL_DIGIT_W{1'b0}}};
         cnt_in  = cnt_ff - CNT_W'(1);
         done_in = (cnt_ff == CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      a_ff   <= a_in;
      b_ff   <= b_in;
      acc_ff <= acc_in;
   end

   assign done = done_ff;
   assign p    = acc_ff;

endmodule

### sv/rap_score.sv
// Sequencer that scores one pair: squares, scaling and the exp series,
// all through the shared multiplier. Depends on rap_pkg, rap_mul, assert_macros.svh.
module rap_score #(
   parameter int OUT_FRAC_BITS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic signed [rap_pkg::DIFF_W-1:0] d_i  [3],
   input  logic        [rap_pkg::DIFF_W-1:0] pa_i [3],
   input  logic                              pa_en,
   input  logic        [rap_pkg::DIFF_W-1:0] na_i [3],
   input  logic                              na_en,
   input  logic                              last,
   input  logic        [rap_pkg::SCALE_W-1:0] dist_scale,
   input  logic        [rap_pkg::SCALE_W-1:0] conf_scale,
   output logic                              idle,
   output logic                              res_valid,
   input  logic                              res_ready,
   output rap_pkg::rsp_type                  res
);
   import rap_pkg::*;
   `include "assert_macros.svh"

   localparam int SH     = 40 - OUT_FRAC_BITS;
   localparam int T_W    = OUT_FRAC_BITS + 40;
   localparam int AX_W   = OUT_FRAC_BITS + 6;
   localparam int V_W    = 31;
   localparam logic signed [32:0] EXP_LIM = 33'sd32 <<< OUT_FRAC_BITS;

   typedef enum logic [1:0] {ST_IDLE, ST_ISSUE, ST_WAIT, ST_FIN} state_type;
   typedef enum logic [2:0] {OP_SQ, OP_DT, OP_CT, OP_T, OP_R, OP_TR, OP_DV} op_type;

   state_type                  state_ff, state_in;
   op_type                     op_ff, op_in;
   logic [1:0]                 ax_ff, ax_in, ph_ff, ph_in;
   logic [3:0]                 k_ff, k_in;
   logic signed [DIFF_W-1:0]   d_ff [3];
   logic [DIFF_W-1:0]          pa_ff [3], na_ff [3];
   logic                       pa_en_ff, na_en_ff, last_ff;
   logic [SQ_SUM_W-1:0]        dsq_ff, dsq_in, csq_ff, csq_in;
   logic signed [OUT_W-1:0]    dt_ff, dt_in, ct_ff, ct_in;
   logic [7:0]                 n_ff, n_in;
   logic [31:0]                f32_ff, f32_in;
   logic [29:0]                r_ff, r_in;
   logic [V_W-1:0]             term_ff, term_in, v_ff, v_in;
   logic [32:0]                sum_ff, sum_in;

   logic                       mul_start, mul_done;
   logic [MUL_A_W-1:0]         mul_a;
   logic [MUL_B_W-1:0]         mul_b;
   logic [MUL_P_W-1:0]         mul_p;

   rap_mul u_mul (
      .clock (clock),
      .reset (reset),
      .start (mul_start),
      .a     (mul_a),
      .b     (mul_b),
      .done  (mul_done),
      .p     (mul_p)
   );

   // square operands: |d|, and its change against the neighbors
   logic [DIFF_W-1:0]   abs_d, sq_op;
   logic signed [DIFF_W:0] dp, dn;
   always_comb begin
      abs_d = d_ff[ax_ff][DIFF_W-1] ? DIFF_W'(-d_ff[ax_ff]) : DIFF_W'(d_ff[ax_ff]);
      dp    = $signed({1'b0, abs_d}) - $signed({1'b0, pa_ff[ax_ff]});
      dn    = $signed({1'b0, abs_d}) - $signed({1'b0, na_ff[ax_ff]});
      unique case (ph_ff)
         2'd0:    sq_op = abs_d;
         2'd1:    sq_op = !pa_en_ff ? '0 : (dp[DIFF_W] ? DIFF_W'(-dp) : DIFF_W'(dp));
         default: sq_op = !na_en_ff ? '0 : (dn[DIFF_W] ? DIFF_W'(-dn) : DIFF_W'(dn));
      endcase
   end

   // clamped exp argument
   logic signed [32:0] x_sum, x_cl, x_abs;
   logic               x_neg;
   always_comb begin
      x_sum = {dt_ff[OUT_W-1], dt_ff} + {ct_ff[OUT_W-1], ct_ff};
      priority if (x_sum > EXP_LIM)  x_cl = EXP_LIM;
      else if (x_sum < -EXP_LIM)     x_cl = -EXP_LIM;
      else                           x_cl = x_sum;
      x_neg = x_cl[32];
      x_abs = x_neg ? -x_cl : x_cl;
   end

   // scale magnitudes
   logic [SCALE_W-1:0] dist_mag, conf_mag;
   assign dist_mag = dist_scale[SCALE_W-1] ? -dist_scale : dist_scale;
   assign conf_mag = conf_scale[SCALE_W-1] ? -conf_scale : conf_scale;

   // multiplier operand select
   always_comb begin
      unique case (op_ff)
         OP_SQ: begin mul_a = MUL_A_W'(sq_op);       mul_b = MUL_B_W'(sq_op); end
         OP_DT: begin mul_a = MUL_A_W'(dsq_ff);      mul_b = MUL_B_W'(dist_mag); end
         OP_CT: begin mul_a = MUL_A_W'(csq_ff);      mul_b = MUL_B_W'(conf_mag); end
         OP_T:  begin mul_a = MUL_A_W'(x_abs[AX_W-1:0]); mul_b = MUL_B_W'(LOG2E_Q32); end
         OP_R:  begin mul_a = MUL_A_W'(f32_ff);      mul_b = MUL_B_W'(LN2_Q32); end
         OP_TR: begin mul_a = MUL_A_W'(term_ff);     mul_b = MUL_B_W'(r_ff); end
         default: begin mul_a = MUL_A_W'(v_ff);      mul_b = MUL_B_W'(recip_q35(k_ff)); end
      endcase
   end
   assign mul_start = (state_ff == ST_ISSUE);

   // scaled term: round half away from zero, saturate
   logic               scale_neg, scale_sat;
   logic [MUL_P_W-1:0] rnd_sum, q_full;
   logic [OUT_W:0]     lim;
   logic [OUT_W-1:0]   q_sat;
   logic signed [OUT_W-1:0] term_val;
   always_comb begin
      scale_neg = (op_ff == OP_DT) ? dist_scale[SCALE_W-1] : conf_scale[SCALE_W-1];
      rnd_sum   = mul_p + (MUL_P_W'(1) << (SH - 1));
      q_full    = rnd_sum >> SH;
      lim       = scale_neg ? {2'b01, {(OUT_W-1){1'b0}}} : {2'b00, {(OUT_W-1){1'b1}}};
      scale_sat = q_full > MUL_P_W'(lim);
      q_sat     = scale_sat ? lim[OUT_W-1:0] : q_full[OUT_W-1:0];
      term_val  = scale_neg ? -$signed(q_sat) : $signed(q_sat);
   end

   // exp split, series divide correction
   logic signed [T_W-1:0]   t_s, n_full;
   logic [V_W-1:0]          q0, q_div;
   logic [V_W+4:0]          rem;
   always_comb begin
      t_s    = x_neg ? -$signed(mul_p[T_W-1:0]) : $signed(mul_p[T_W-1:0]);
      n_full = t_s >>> (OUT_FRAC_BITS + 32);
      q0     = mul_p[RECIP_SHIFT+V_W-1:RECIP_SHIFT];
      rem    = (V_W+5)'(v_ff) - (V_W+5)'(q0) * (V_W+5)'(k_ff);
      q_div  = (rem >= (V_W+5)'(k_ff)) ? q0 + V_W'(1) : q0;
   end

   // final scale of the series sum by 2^(n + frac - 30)
   logic [8:0]   s_exp, rsh;
   logic [33:0]  sh_up, rr;
   logic [31:0]  prob;
   always_comb begin
      s_exp = 9'({n_ff[7], n_ff} + 9'(OUT_FRAC_BITS) - 9'd30);
      rsh   = -s_exp;
      sh_up = (s_exp == 9'd1) ? {sum_ff, 1'b0} : {1'b0, sum_ff};
      rr    = ({1'b0, sum_ff} + (34'd1 << (rsh[4:0] - 5'd1))) >> rsh[4:0];
      priority if (!s_exp[8] && s_exp >= 9'd2) prob = '1;
      else if (!s_exp[8])        prob = (sh_up > 34'hFFFF_FFFF) ? '1 : sh_up[31:0];
      else if (rsh[8:5] != '0)   prob = '0;
      else                       prob = rr[31:0];
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      ax_in    = ax_ff;
      ph_in    = ph_ff;
      k_in     = k_ff;
      dsq_in   = dsq_ff;
      csq_in   = csq_ff;
      dt_in    = dt_ff;
      ct_in    = ct_ff;
      n_in     = n_ff;
      f32_in   = f32_ff;
      r_in     = r_ff;
      term_in  = term_ff;
      v_in     = v_ff;
      sum_in   = sum_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_ISSUE;
               op_in    = OP_SQ;
               ax_in    = '0;
               ph_in    = '0;
               dsq_in   = '0;
               csq_in   = '0;
            end
         end
         ST_ISSUE: state_in = ST_WAIT;
         ST_WAIT: begin
            if (mul_done) begin
               state_in = ST_ISSUE;
               unique case (op_ff)
                  OP_SQ: begin
                     if (ph_ff == 2'd0) dsq_in = dsq_ff + mul_p[SQ_SUM_W-1:0];
                     else               csq_in = csq_ff + mul_p[SQ_SUM_W-1:0];
                     if (ph_ff == 2'd2) begin
                        ph_in = '0;
                        if (ax_ff == 2'd2) op_in = OP_DT;
                        else               ax_in = ax_ff + 2'd1;
                     end else begin
                        ph_in = ph_ff + 2'd1;
                     end
                  end
                  OP_DT: begin dt_in = term_val; op_in = OP_CT; end
                  OP_CT: begin ct_in = term_val; op_in = OP_T;  end
                  OP_T: begin
                     n_in   = n_full[7:0];
                     f32_in = t_s[OUT_FRAC_BITS+31 -: 32];
                     op_in  = OP_R;
                  end
                  OP_R: begin
                     r_in    = mul_p[63:34];
                     term_in = V_W'(1) << 30;
                     sum_in  = 33'd1 << 30;
                     k_in    = 4'd1;
                     op_in   = OP_TR;
                  end
                  OP_TR: begin v_in = mul_p[V_W+29:30]; op_in = OP_DV; end
                  default: begin
                     term_in = q_div;
                     sum_in  = sum_ff + 33'(q_div);
                     if (k_ff == 4'(SERIES_TERMS)) begin
                        state_in = ST_FIN;
                     end else begin
                        k_in  = k_ff + 4'd1;
                        op_in = OP_TR;
                     end
                  end
               endcase
            end
         end
         default: begin
            if (res_ready) state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         op_ff    <= OP_SQ;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
      end
      ax_ff   <= ax_in;
      ph_ff   <= ph_in;
      k_ff    <= k_in;
      dsq_ff  <= dsq_in;
      csq_ff  <= csq_in;
      dt_ff   <= dt_in;
      ct_ff   <= ct_in;
      n_ff    <= n_in;
      f32_ff  <= f32_in;
      r_ff    <= r_in;
      term_ff <= term_in;
      v_ff    <= v_in;
      sum_ff  <= sum_in;
      if (start && state_ff == ST_IDLE) begin
         d_ff     <= d_i;
         pa_ff    <= pa_i;
         na_ff    <= na_i;
         pa_en_ff <= pa_en;
         na_en_ff <= na_en;
         last_ff  <= last;
      end
   end

   assign idle      = (state_ff == ST_IDLE);
   assign res_valid = (state_ff == ST_FIN);
   assign res.probability = prob;
   assign res.dist_term   = dt_ff;
   assign res.conf_term   = ct_ff;
   assign res.last_of_run = last_ff;

   `RAP_ASSERT(a_done_in_wait, clock, reset, mul_done |-> state_ff == ST_WAIT, "mul done outside wait")
   `RAP_ASSERT(a_issue_then_wait, clock, reset, state_ff == ST_ISSUE |=> state_ff == ST_WAIT, "issue not followed by wait")
   `RAP_ASSERT(a_k_range, clock, reset, (state_ff == ST_WAIT && op_ff == OP_DV) |-> (k_ff >= 4'd1 && k_ff <= 4'(SERIES_TERMS)), "series index out of range")

endmodule

### sv/rossmann_argos_pair_score.sv
// Rossmann-Argos pair scorer. Each request carries one aligned residue pair; its
// result is emitted when the next pair arrives (that pair gives the "next" term),
// so a pair with run_end set emits the pending result and then its own. One result
// takes nine squares, two scale products, two exponent-split products and 28 series
// products, 41 in all, each issued and awaited in turn on the single shared 52x16
// digit multiplier. A request holds the input until its result, and the pending result
// that it also flushes, if any, is taken into the rsp register. req_ready is high only
// while no pair is in work; a finished result waits in the rsp register while the
// next request is taken.
// Depends on rap_pkg, rap_score, rap_mul, assert_macros.svh.
module rossmann_argos_pair_score #(
   parameter int OUT_FRAC_BITS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  rap_pkg::req_type                  req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output rap_pkg::rsp_type                  rsp_data,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [rap_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [rap_pkg::SCALE_W-1:0]       csr_data
);
   import rap_pkg::*;
   `include "assert_macros.svh"

   typedef enum logic [2:0] {T_IDLE, T_PICK, T_JOB1, T_WAIT1, T_JOB2, T_WAIT2} state_type;

   state_type                state_ff, state_in;
   logic [SCALE_W-1:0]       dist_scale_ff, conf_scale_ff;
   logic signed [DIFF_W-1:0] held_ff [3], cur_ff [3];
   logic [DIFF_W-1:0]        older_ff [3], held_abs [3], cur_abs [3];
   logic                     held_valid_ff, held_start_ff, rs_ff, re_ff;
   logic                     rsp_valid_ff;
   rsp_type                  rsp_data_ff;
   logic                     do_update;

   logic                     score_start, score_idle, res_valid, res_ready, res_fire;
   logic signed [DIFF_W-1:0] job_d [3];
   logic [DIFF_W-1:0]        job_pa [3], job_na [3];
   logic                     job_pa_en, job_na_en, job_last;
   rsp_type                  res;

   // config writes
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         dist_scale_ff <= '0;
         conf_scale_ff <= '0;
      end else if (csr_valid) begin
         if (csr_index == CSR_DIST_SCALE) dist_scale_ff <= csr_data;
         if (csr_index == CSR_CONF_SCALE) conf_scale_ff <= csr_data;
      end
   end

   // magnitudes of current and held differences
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         held_abs[i] = held_ff[i][DIFF_W-1] ? DIFF_W'(-held_ff[i]) : DIFF_W'(held_ff[i]);
         cur_abs[i]  = cur_ff[i][DIFF_W-1]  ? DIFF_W'(-cur_ff[i])  : DIFF_W'(cur_ff[i]);
      end
   end

   // job operands: pending pair in JOB1, the run-end pair in JOB2
   always_comb begin
      job_pa_en = (state_ff == T_JOB1) ? !held_start_ff : !rs_ff;
      job_na_en = (state_ff == T_JOB1);
      job_last  = (state_ff != T_JOB1);
      for (int i = 0; i < 3; i++) begin
         job_d[i]  = (state_ff == T_JOB1) ? held_ff[i]  : cur_ff[i];
         job_pa[i] = (state_ff == T_JOB1) ? older_ff[i] : held_abs[i];
         job_na[i] = cur_abs[i];
      end
   end

   assign score_start = (state_ff == T_JOB1) || (state_ff == T_JOB2);
   assign res_ready   = !rsp_valid_ff || rsp_ready;
   assign res_fire    = res_valid && res_ready;

   rap_score #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_score (
      .clock      (clock),
      .reset      (reset),
      .start      (score_start),
      .d_i        (job_d),
      .pa_i       (job_pa),
      .pa_en      (job_pa_en),
      .na_i       (job_na),
      .na_en      (job_na_en),
      .last       (job_last),
      .dist_scale (dist_scale_ff),
      .conf_scale (conf_scale_ff),
      .idle       (score_idle),
      .res_valid  (res_valid),
      .res_ready  (res_ready),
      .res        (res)
   );

   // request sequencing
   always_comb begin
      state_in  = state_ff;
      do_update = 1'b0;
      unique case (state_ff)
         T_IDLE:  if (req_valid) state_in = T_PICK;
         T_PICK: begin
            priority if (held_valid_ff) state_in = T_JOB1;
            else if (re_ff)             state_in = T_JOB2;
            else begin
               do_update = 1'b1;
               state_in  = T_IDLE;
            end
         end
         T_JOB1:  state_in = T_WAIT1;
         T_WAIT1: begin
            if (res_fire) begin
               if (re_ff) state_in = T_JOB2;
               else begin
                  do_update = 1'b1;
                  state_in  = T_IDLE;
               end
            end
         end
         T_JOB2:  state_in = T_WAIT2;
         default: begin
            if (res_fire) begin
               do_update = 1'b1;
               state_in  = T_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= T_IDLE;
         held_valid_ff <= 1'b0;
         held_start_ff <= 1'b0;
         for (int i = 0; i < 3; i++) begin
            held_ff[i]  <= '0;
            older_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         if (do_update) begin
            held_valid_ff <= !re_ff;
            if (!re_ff) held_start_ff <= rs_ff;
            for (int i = 0; i < 3; i++) begin
               older_ff[i] <= held_abs[i];
               held_ff[i]  <= cur_ff[i];
            end
         end
      end
      if (req_valid && req_ready) begin
         cur_ff[0] <= DIFF_W'(req_data.first_x) - DIFF_W'(req_data.second_x);
         cur_ff[1] <= DIFF_W'(req_data.first_y) - DIFF_W'(req_data.second_y);
         cur_ff[2] <= DIFF_W'(req_data.first_z) - DIFF_W'(req_data.second_z);
         rs_ff     <= req_data.run_start;
         re_ff     <= req_data.run_end;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (res_fire) rsp_data_ff <= res;
   end

   assign req_ready = (state_ff == T_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `RAP_ASSERT(a_busy_after_accept, clock, reset,
      (req_valid && req_ready) |=> !req_ready, "ready after accept")
   `RAP_ASSERT(a_start_when_idle, clock, reset,
      score_start |-> score_idle, "score started while busy")
   `RAP_ASSERT(a_no_overwrite, clock, reset,
      res_fire |-> (!rsp_valid_ff || rsp_ready), "result register overwritten")

endmodule
